// ----- rtl/planar_odometry_dead_reckoning_macros.svh -----
// Assertion macros for the planar odometry integrator checker.
// They expect i_clk and i_rst_n to be visible where they are used.
`ifndef PLANAR_ODOMETRY_DEAD_RECKONING_MACROS_SVH
`define PLANAR_ODOMETRY_DEAD_RECKONING_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define POD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry integrator: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define POD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry integrator: same-cycle property failed");

`endif

// ----- rtl/pod_pkg.sv -----
// Shared types, command codes and constants of the planar odometry integrator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pod_pkg;

    // CORDIC arctangent table and datapath widths.
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int CORDIC_W     = 36;
    localparam int Z_W          = 34;
    localparam int MUL_A_W      = 41;
    localparam int PROD_W       = 58;
    localparam int ACC_W        = 64;
    localparam int P_W          = 40;

    // Constant multipliers split into 16-bit halves for the shared multiplier.
    localparam logic [15:0] INV_GAIN_HI = 16'd2487;
    localparam logic [15:0] INV_GAIN_LO = 16'd20187;
    localparam logic [15:0] INV_PI_HI   = 16'd81;
    localparam logic [15:0] INV_PI_LO   = 16'd31938;

    // Multiplier operand selection.
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_VX   = 4'd1;
    localparam logic [3:0] MUL_VY   = 4'd2;
    localparam logic [3:0] MUL_WR   = 4'd3;
    localparam logic [3:0] MUL_PL   = 4'd4;
    localparam logic [3:0] MUL_PH   = 4'd5;
    localparam logic [3:0] MUL_XL   = 4'd6;
    localparam logic [3:0] MUL_XH   = 4'd7;
    localparam logic [3:0] MUL_YL   = 4'd8;
    localparam logic [3:0] MUL_YH   = 4'd9;

    // Accumulator operations.
    localparam logic [2:0] ACC_NONE  = 3'd0;
    localparam logic [2:0] ACC_DX    = 3'd1;
    localparam logic [2:0] ACC_P     = 3'd2;
    localparam logic [2:0] ACC_DH    = 3'd3;
    localparam logic [2:0] ACC_ROT   = 3'd4;
    localparam logic [2:0] ACC_ADD16 = 3'd5;

    // Register write-back targets.
    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_X    = 3'd1;
    localparam logic [2:0] WR_Y    = 3'd2;
    localparam logic [2:0] WR_P    = 3'd3;
    localparam logic [2:0] WR_HEAD = 3'd4;
    localparam logic [2:0] WR_POSX = 3'd5;
    localparam logic [2:0] WR_POSY = 3'd6;

    typedef struct packed {
        logic               clear_first;
        logic [15:0]        time_step;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] yaw_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic [31:0]        elapsed;
    } t_out;

    typedef struct packed {
        logic                  load;
        logic [3:0]            mul;
        logic [2:0]            acc;
        logic [2:0]            wr;
        logic                  cordic_en;
        logic [ATAN_IDX_W-1:0] cordic_idx;
        logic                  out_load;
    } t_cmd;

    // atan(2^-i) in units of pi / 2^31.
    function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/pod_datapath.sv -----
// Datapath of the planar odometry integrator: pose registers, shared multiplier,
// accumulator, CORDIC rotator and output register. Depends on pod_pkg.
`timescale 1ns / 1ps

module pod_datapath import pod_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_data,
    output t_out o_data
);

    localparam logic signed [Z_W-1:0]   Z_QUARTER = Z_W'(64'sd1 <<< 30);
    localparam logic signed [Z_W-1:0]   Z_HALF    = Z_W'(64'sd1 <<< 31);
    localparam logic signed [ACC_W-1:0] RC_DX     = ACC_W'(64'sd1 <<< 15);
    localparam logic signed [ACC_W-1:0] RC_DH     = ACC_W'(64'sd1 <<< 40);
    localparam logic signed [ACC_W-1:0] RC_ROT    = ACC_W'(64'sd1 <<< 35);
    localparam logic signed [33:0]      POS_MAX   = 34'sd2147483647;
    localparam logic signed [33:0]      POS_MIN   = -34'sd2147483648;

    t_in                       r_in;
    logic signed [31:0]        r_pos_x;
    logic signed [31:0]        r_pos_y;
    logic [15:0]               r_heading;
    logic [31:0]               r_time;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [Z_W-1:0]     r_z;
    logic                      r_neg;
    logic signed [P_W-1:0]     r_p;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_out                      r_out;

    logic [15:0]                head_base;
    logic signed [Z_W-1:0]      z0;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [15:0]                mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [CORDIC_W-1:0] d_vec;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [Z_W-1:0]      z_step;
    logic signed [27:0]         rot;
    logic signed [33:0]         sum_x;
    logic signed [33:0]         sum_y;
    logic [32:0]                t_sum;

    function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > POS_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < POS_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Heading held before this item, after an optional clear.
    assign head_base = i_data.clear_first ? 16'd0 : r_heading;
    assign z0        = {{(Z_W - 32){head_base[15]}}, head_base, 16'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            MUL_VX: begin mul_a = MUL_A_W'(r_in.vel_x);    mul_b = r_in.time_step; end
            MUL_VY: begin mul_a = MUL_A_W'(r_in.vel_y);    mul_b = r_in.time_step; end
            MUL_WR: begin mul_a = MUL_A_W'(r_in.yaw_rate); mul_b = r_in.time_step; end
            MUL_PL: begin mul_a = MUL_A_W'(r_p);           mul_b = INV_PI_LO;      end
            MUL_PH: begin mul_a = MUL_A_W'(r_p);           mul_b = INV_PI_HI;      end
            MUL_XL: begin mul_a = MUL_A_W'(r_x);           mul_b = INV_GAIN_LO;    end
            MUL_XH: begin mul_a = MUL_A_W'(r_x);           mul_b = INV_GAIN_HI;    end
            MUL_YL: begin mul_a = MUL_A_W'(r_y);           mul_b = INV_GAIN_LO;    end
            MUL_YH: begin mul_a = MUL_A_W'(r_y);           mul_b = INV_GAIN_HI;    end
            default: begin mul_a = '0;                     mul_b = '0;             end
        endcase
    end

    assign prod_ext = ACC_W'(r_prod);
    // Rounded displacement, scaled by the guard bits.
    assign d_vec    = {r_acc[CORDIC_W+7:16], 8'b0};
    assign x_sh     = r_x >>> i_cmd.cordic_idx;
    assign y_sh     = r_y >>> i_cmd.cordic_idx;
    assign z_step   = Z_W'(atan_entry(i_cmd.cordic_idx));
    assign rot      = r_acc[63:36];
    assign sum_x    = 34'(r_pos_x) + 34'(rot);
    assign sum_y    = 34'(r_pos_y) + 34'(rot);
    assign t_sum    = {1'b0, r_time} + {17'b0, r_in.time_step};

    // Pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_time    <= '0;
        end else begin
            if (i_cmd.load && i_data.clear_first) begin
                r_pos_x   <= '0;
                r_pos_y   <= '0;
                r_heading <= '0;
                r_time    <= '0;
            end
            case (i_cmd.wr)
                WR_HEAD: r_heading <= r_heading + r_acc[56:41];
                WR_POSX: r_pos_x   <= sat_pos(sum_x);
                WR_POSY: begin
                    r_pos_y <= sat_pos(sum_y);
                    r_time  <= t_sum[32] ? 32'hFFFFFFFF : t_sum[31:0];
                end
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_data;
            if (z0 > Z_QUARTER) begin
                r_z   <= z0 - Z_HALF;
                r_neg <= 1'b1;
            end else if (z0 < -Z_QUARTER) begin
                r_z   <= z0 + Z_HALF;
                r_neg <= 1'b1;
            end else begin
                r_z   <= z0;
                r_neg <= 1'b0;
            end
        end

        r_prod <= mul_a * $signed({1'b0, mul_b});

        case (i_cmd.acc)
            ACC_DX:    r_acc <= RC_DX + prod_ext;
            ACC_P:     r_acc <= prod_ext;
            ACC_DH:    r_acc <= RC_DH + prod_ext;
            ACC_ROT:   r_acc <= RC_ROT + prod_ext;
            ACC_ADD16: r_acc <= r_acc + (prod_ext <<< 16);
            default:   ;
        endcase

        if (i_cmd.wr == WR_X) begin
            r_x <= r_neg ? -d_vec : d_vec;
        end else if (i_cmd.wr == WR_Y) begin
            r_y <= r_neg ? -d_vec : d_vec;
        end else if (i_cmd.cordic_en) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - z_step;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + z_step;
            end
        end

        if (i_cmd.wr == WR_P) begin
            r_p <= r_acc[P_W-1:0];
        end

        if (i_cmd.out_load) begin
            r_out.pos_x   <= r_pos_x;
            r_out.pos_y   <= r_pos_y;
            r_out.heading <= r_heading;
            r_out.elapsed <= r_time;
        end
    end

    assign o_data = r_out;

endmodule

// ----- rtl/pod_ctrl.sv -----
// Sequencer of the planar odometry integrator: handshakes and the per-cycle
// command schedule for the datapath. Depends on pod_pkg.
`timescale 1ns / 1ps

module pod_ctrl import pod_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    localparam int LAST  = 10 + STEPS;
    localparam int CNT_W = $clog2(LAST + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] T_VX     = CNT_W'(1);
    localparam logic [CNT_W-1:0] T_VY     = CNT_W'(2);
    localparam logic [CNT_W-1:0] T_WR     = CNT_W'(3);
    localparam logic [CNT_W-1:0] T_P      = CNT_W'(4);
    localparam logic [CNT_W-1:0] T_PW     = CNT_W'(5);
    localparam logic [CNT_W-1:0] T_PL     = CNT_W'(6);
    localparam logic [CNT_W-1:0] T_PH     = CNT_W'(7);
    localparam logic [CNT_W-1:0] T_DH     = CNT_W'(8);
    localparam logic [CNT_W-1:0] T_HEAD   = CNT_W'(9);
    localparam logic [CNT_W-1:0] T_C_LAST = CNT_W'(4 + STEPS);
    localparam logic [CNT_W-1:0] T_XL     = CNT_W'(5 + STEPS);
    localparam logic [CNT_W-1:0] T_XH     = CNT_W'(6 + STEPS);
    localparam logic [CNT_W-1:0] T_YL     = CNT_W'(7 + STEPS);
    localparam logic [CNT_W-1:0] T_YH     = CNT_W'(8 + STEPS);
    localparam logic [CNT_W-1:0] T_YSUM   = CNT_W'(9 + STEPS);
    localparam logic [CNT_W-1:0] T_END    = CNT_W'(LAST);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_load;
    logic [CNT_W-1:0] c_off;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || !i_stall);
    assign c_off    = r_cnt - T_PW;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                    n_cnt   = T_VX;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == T_END) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.mul        = MUL_NONE;
        o_cmd.acc        = ACC_NONE;
        o_cmd.wr         = WR_NONE;
        o_cmd.load       = accept;
        o_cmd.out_load   = out_load;
        o_cmd.cordic_en  = (r_state == S_RUN) && (r_cnt >= T_PW) && (r_cnt <= T_C_LAST);
        o_cmd.cordic_idx = c_off[ATAN_IDX_W-1:0];
        if (r_state == S_RUN) begin
            unique case (r_cnt)
                T_VX:   o_cmd.mul = MUL_VX;
                T_VY:   begin o_cmd.mul = MUL_VY; o_cmd.acc = ACC_DX; end
                T_WR:   begin o_cmd.mul = MUL_WR; o_cmd.acc = ACC_DX; o_cmd.wr = WR_X; end
                T_P:    begin o_cmd.acc = ACC_P;  o_cmd.wr = WR_Y; end
                T_PW:   o_cmd.wr  = WR_P;
                T_PL:   o_cmd.mul = MUL_PL;
                T_PH:   begin o_cmd.mul = MUL_PH; o_cmd.acc = ACC_DH; end
                T_DH:   o_cmd.acc = ACC_ADD16;
                T_HEAD: o_cmd.wr  = WR_HEAD;
                T_XL:   o_cmd.mul = MUL_XL;
                T_XH:   begin o_cmd.mul = MUL_XH; o_cmd.acc = ACC_ROT; end
                T_YL:   begin o_cmd.mul = MUL_YL; o_cmd.acc = ACC_ADD16; end
                T_YH:   begin o_cmd.mul = MUL_YH; o_cmd.acc = ACC_ROT; o_cmd.wr = WR_POSX; end
                T_YSUM: o_cmd.acc = ACC_ADD16;
                T_END:  o_cmd.wr  = WR_POSY;
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- rtl/planar_odometry_dead_reckoning.sv -----
// Planar wheel-odometry integrator, top level: sequencer plus datapath.
// Depends on pod_pkg, pod_ctrl and pod_datapath.
//
// Each transfer on the input channel carries a time step, a body-frame velocity
// and a yaw rate; the block rotates the displacement by the heading held before
// the item, accumulates position, heading and elapsed time, and delivers one
// result transfer with the new pose. Each item is taken, then worked on by the single
// shared 41x17 multiplier and its accumulator wrapped around one CORDIC shift-add
// stage that iterates once per step for min(CORDIC_STEPS, 24) steps, and its result
// is then posted. The input is stalled while an item is worked on and posted; a
// finished result sits in the output register, so the next item is taken while that
// result still waits to be collected. If the previous result has not been taken when
// the next one is ready, the block holds in its finish state until the output
// register frees. Setting clear_first zeroes the pose and elapsed time before the
// item is applied. Position and elapsed time saturate; the heading is a binary angle
// and wraps. There are no configuration registers.
`timescale 1ns / 1ps

module planar_odometry_dead_reckoning import pod_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // The arctangent table bounds the number of rotation steps.
    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    t_cmd cmd;

    pod_ctrl #(
        .STEPS(STEPS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_cmd  (cmd)
    );

    pod_datapath u_datapath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_data (i_data),
        .o_data (o_data)
    );

endmodule

// ----- rtl/pod_checker.sv -----
// Port-level checker for the planar odometry integrator and its bind.
// Depends on pod_pkg and planar_odometry_dead_reckoning_macros.svh.
`timescale 1ns / 1ps
`include "planar_odometry_dead_reckoning_macros.svh"

module pod_checker import pod_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // A taken item keeps the input stalled while it is worked on.
    `POD_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)

    // With no result pending, a result cannot appear right after a transfer in.
    `POD_ASSERT_NEXT(a_no_instant_result, i_valid && !o_stall && !o_valid, !o_valid)

    // A new result is posted in the same cycle the block becomes free again.
    `POD_ASSERT_NOW(a_post_frees_input, $rose(o_valid), !o_stall)

    // A stalled result holds.
    `POD_ASSERT_NEXT(a_result_holds, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

bind planar_odometry_dead_reckoning pod_checker u_pod_checker (.*);

// ----- test/planar_odometry_dead_reckoning_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the planar odometry integrator: random and directed motion
// items, an in-line pose predictor and a field-by-field check of every result transfer.
// Depends on pod_pkg and planar_odometry_dead_reckoning.

module planar_odometry_dead_reckoning_tb;
    import pod_pkg::*;

    // The block is built with its default CORDIC depth. The predictor uses the same depth.
    localparam int     ROT_STEPS     = 16;
    localparam int     GUARD         = 8;
    localparam longint INV_GAIN      = 64'sd163008219;
    localparam longint INV_PI        = 64'sd5340354;
    // The run is about 1150 items plus the receiver hold-off, all well within the limit.
    localparam longint CYCLE_LIMIT   = 64'sd400000;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     STRAIGHT_RUN  = 260;

    localparam logic [15:0]        DT_MAX = 16'hFFFF;
    localparam logic signed [23:0] V_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] V_MIN  = 24'sh800000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Sender side of the input channel.
    logic drv_valid = 1'b0;
    t_in  drv_data  = '0;
    logic dut_stall;

    // Receiver side of the result channel.
    logic dut_valid;
    t_out dut_data;
    logic rx_stall = 1'b0;

    // Items waiting to be offered, and poses that the block still owes us.
    t_in  odo_q[$];
    t_out pose_q[$];

    // Predicted state of the integrator.
    logic signed [31:0] est_x    = '0;
    logic signed [31:0] est_y    = '0;
    logic signed [15:0] est_head = '0;
    logic [31:0]        est_time = '0;

    // Idle rates in percent. The long receiver hold-off is requested from the stimulus
    // process and counted down by the receiver.
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_req      = 0;
    int     hold_left     = 0;
    int     n_fail        = 0;
    longint cycle_cnt     = 0;

    always #5 i_clk = ~i_clk;

    planar_odometry_dead_reckoning #(
        .CORDIC_STEPS(ROT_STEPS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(drv_valid),
        .o_stall(dut_stall),
        .i_data (drv_data),
        .o_valid(dut_valid),
        .i_stall(rx_stall),
        .o_data (dut_data)
    );

    // Arctangent of 2^-i in units of pi / 2^31.
    function automatic longint atan_step(input int idx);
        case (idx)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            default: return 64'h0;
        endcase
    endfunction

    // Divide by 2^n and round half up. The arithmetic shift on a signed value is a floor.
    function automatic longint round_half_up(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Applies one accepted item to the predicted state and queues the pose it must produce.
    task automatic integrate_odometry(input t_in it);
        longint dt;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint dh;
        longint t;
        int     i;
        if (it.clear_first) begin
            est_x    = '0;
            est_y    = '0;
            est_head = '0;
            est_time = '0;
        end
        dt = longint'({48'd0, it.time_step});

        // Body-frame displacement, with guard bits for the rotation.
        x = round_half_up(longint'($signed(it.vel_x)) * dt, 16) * (64'sd1 <<< GUARD);
        y = round_half_up(longint'($signed(it.vel_y)) * dt, 16) * (64'sd1 <<< GUARD);

        // The rotation uses the heading held before this item. Outside +-pi/2 the vector
        // is turned by pi first so that the CORDIC stays within its range.
        z = longint'(est_head) * 64'sd65536;
        if (z > (64'sd1 <<< 30)) begin
            x = -x;
            y = -y;
            z = z - (64'sd1 <<< 31);
        end else if (z < -(64'sd1 <<< 30)) begin
            x = -x;
            y = -y;
            z = z + (64'sd1 <<< 31);
        end
        for (i = 0; i < ROT_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
        end
        est_x = clamp32(longint'(est_x) + round_half_up(x * INV_GAIN, 28 + GUARD));
        est_y = clamp32(longint'(est_y) + round_half_up(y * INV_GAIN, 28 + GUARD));

        // The heading is a binary angle, so keeping the low 16 bits is the wrap.
        dh = round_half_up(longint'($signed(it.yaw_rate)) * dt * INV_PI, 41);
        est_head = est_head + dh[15:0];

        t = longint'({32'd0, est_time}) + dt;
        est_time = (t > 64'sd4294967295) ? 32'hFFFFFFFF : t[31:0];

        pose_q.insert(pose_q.size(), t_out'({est_x, est_y, est_head, est_time}));
    endtask

    // Finds the yaw rate that turns the heading by exactly the given number of angle
    // units over a full-length time step.
    function automatic logic [23:0] yaw_for_turn(input int ticks);
        longint guess;
        longint wr;
        guess = (longint'(ticks) <<< 41) / (64'sd65535 * INV_PI);
        for (wr = guess - 64; wr <= guess + 64; wr++) begin
            if (round_half_up(wr * 64'sd65535 * INV_PI, 41) == longint'(ticks))
                return wr[23:0];
        end
        return guess[23:0];
    endfunction

    // Extremes, small values around zero and full-range values, mixed.
    function automatic logic [23:0] rand_q24();
        case ($urandom_range(7))
            0:       return V_MAX;
            1:       return V_MIN;
            2, 3:    return 24'($signed($urandom_range(2048)) - 1024);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        it.clear_first = ($urandom_range(19) == 0);
        case ($urandom_range(19))
            0:                     it.time_step = '0;
            1, 2:                  it.time_step = DT_MAX;
            3, 4, 5, 6, 7, 8, 9:   it.time_step = 16'($urandom_range(255));
            default:               it.time_step = 16'($urandom_range(65535));
        endcase
        it.vel_x    = rand_q24();
        it.vel_y    = rand_q24();
        it.yaw_rate = rand_q24();
        return it;
    endfunction

    task automatic push_item(input logic clr, input logic [15:0] dt, input logic [23:0] vx,
                             input logic [23:0] vy, input logic [23:0] wr);
        t_in it;
        it.clear_first = clr;
        it.time_step   = dt;
        it.vel_x       = vx;
        it.vel_y       = vy;
        it.yaw_rate    = wr;
        odo_q.insert(odo_q.size(), it);
    endtask

    // Drives a straight line from a cleared pose at full speed, long enough to saturate
    // both position components.
    task automatic push_straight(input logic [23:0] vx, input logic [23:0] vy);
        push_item(1'b1, DT_MAX, vx, vy, '0);
        repeat (STRAIGHT_RUN - 1)
            push_item(1'b0, DT_MAX, vx, vy, '0);
    endtask

    // The sender stops here until every queued item has been taken and every pose has
    // come back. The check runs at the falling edge, where all updates have settled.
    task automatic wait_drained();
        while (odo_q.size() != 0 || drv_valid || pose_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        n_fail++;
    endtask

    // Sender. An item is taken at an edge where valid is high and the block does not
    // stall. The predictor runs on that same edge. Valid and data get one nonblocking
    // update per edge, so back-to-back transfers keep valid high with no glitch.
    always @(posedge i_clk) begin : drive
        logic nxt_valid;
        t_in  nxt_data;
        nxt_valid = drv_valid;
        nxt_data  = drv_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (drv_valid && !dut_stall) begin
                integrate_odometry(drv_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && odo_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_data  = odo_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        drv_valid <= nxt_valid;
        drv_data  <= nxt_data;
    end

    // Receiver. Each pose transfer is compared with the oldest prediction. The stall is
    // random, except during a requested hold-off. The hold-off lets the output register
    // and the datapath fill, so the block has to stall its input.
    always @(posedge i_clk) begin : collect
        t_out want;
        if (i_rst_n && dut_valid && !rx_stall) begin
            if (pose_q.size() == 0) begin
                report_mismatch("unexpected pose", 0, 0);
            end else begin
                want = pose_q.pop_front();
                if (dut_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", dut_data.pos_x, want.pos_x);
                if (dut_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", dut_data.pos_y, want.pos_y);
                if (dut_data.heading !== want.heading)
                    report_mismatch("heading", dut_data.heading, want.heading);
                if (dut_data.elapsed !== want.elapsed)
                    report_mismatch("elapsed", longint'({32'd0, dut_data.elapsed}),
                                    longint'({32'd0, want.elapsed}));
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_stall <= 1'b1;
        end else begin
            rx_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog. A block that hangs or loses a pose ends up here.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d poses outstanding", cycle_cnt,
                     pose_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First phase: a slow receiver and a sender that rarely pauses.
        send_idle_pct = 8;
        recv_idle_pct = 74;

        // Directed items: a zero item, a zero time step with full-scale rates, both
        // full-scale corners, and a clear. Then a tie at half an LSB that must round
        // up, and a clear that arrives with a zero step.
        push_item(1'b0, '0, '0, '0, '0);
        push_item(1'b0, '0, V_MAX, V_MIN, V_MAX);
        push_item(1'b0, DT_MAX, V_MAX, V_MAX, V_MAX);
        push_item(1'b0, DT_MAX, V_MIN, V_MIN, V_MIN);
        push_item(1'b1, 16'd1, 24'sd1, -24'sd1, -24'sd1);
        push_item(1'b0, 16'h8000, 24'sd1, -24'sd1, '0);
        push_item(1'b1, '0, V_MAX, V_MAX, V_MAX);

        // Walk the heading onto the quadrant boundaries. Each item moves with the
        // heading left by the previous one and then turns: to exactly +pi/2, just past
        // it, to the last angle below pi, across the wrap to -pi, to exactly -pi/2 and
        // just past it.
        push_item(1'b1, DT_MAX, V_MAX, '0, yaw_for_turn(16384));
        push_item(1'b0, DT_MAX, 24'sh3E8000, -24'sd12345, yaw_for_turn(1));
        push_item(1'b0, DT_MAX, V_MIN, V_MAX, yaw_for_turn(16382));
        push_item(1'b0, DT_MAX, 24'sh123456, 24'sh654321, yaw_for_turn(1));
        push_item(1'b0, DT_MAX, V_MAX, V_MAX, yaw_for_turn(16384));
        push_item(1'b0, DT_MAX, V_MIN, 24'sh00F000, yaw_for_turn(-1));
        push_item(1'b0, DT_MAX, V_MAX, V_MIN, '0);

        repeat (150)
            odo_q.insert(odo_q.size(), random_item());
        // The receiver holds off for a long stretch while the sender keeps offering.
        hold_req = HOLD_CYCLES;
        repeat (125)
            odo_q.insert(odo_q.size(), random_item());
        wait_drained();

        // Second phase: a bursty sender and a receiver that is almost always ready.
        send_idle_pct = 74;
        recv_idle_pct = 8;
        repeat (250)
            odo_q.insert(odo_q.size(), random_item());
        wait_drained();

        // Third phase: full throughput on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (100)
            odo_q.insert(odo_q.size(), random_item());

        // Position saturation, once toward +x/-y and once toward -x/+y.
        push_straight(V_MAX, V_MIN);
        push_straight(V_MIN, V_MAX);
        wait_drained();

        // Leave time for a stray extra pose to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
